FILE: src/obpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obpe_pkg
// Shared types and constants of the oscillometric blood pressure estimator.
// ----------------------------------------------------------------------------
package obpe_pkg;

   localparam int MAX_PULSES = 64;
   localparam int ADDR_W     = $clog2(MAX_PULSES);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int SUM_W      = 16 + ADDR_W;
   localparam int DIV_W      = 27;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int CSR_ADDR_W = 5;

   localparam logic [13:0] RATE_SCALE = 14'd15360;

   localparam logic [15:0] SYS_RATIO_RST = 16'd42598;
   localparam logic [15:0] DIA_RATIO_RST = 16'd45875;
   localparam logic [15:0] DEV_RATIO_RST = 16'd13107;
   localparam logic [15:0] IRR_FRAC_RST  = 16'd13107;
   localparam logic [12:0] SRATE_RST     = 13'd100;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      CSR_SYS_RATIO = 3'd0,
      CSR_DIA_RATIO = 3'd1,
      CSR_DEV_RATIO = 3'd2,
      CSR_IRR_FRAC  = 3'd3,
      CSR_SRATE     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] cuff_pressure;
      logic [15:0] amplitude;
      logic [15:0] sample_index;
      logic        last_pulse;
   } req_type;

   typedef struct packed {
      logic [15:0] mean_pressure;
      logic [15:0] systolic_pressure;
      logic [15:0] diastolic_pressure;
      logic [15:0] pulse_rate;
      logic [7:0]  irregular_beats;
      logic        irregular_run;
      logic [7:0]  irregular_run_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pressure;
      logic [15:0] amplitude;
      logic [15:0] index;
   } rec_type;

   typedef enum logic {
      CMD_CLEAR  = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic [15:0] sys_ratio;
      logic [15:0] dia_ratio;
      logic [15:0] dev_ratio;
      logic [15:0] irr_frac;
      logic [12:0] srate;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P1_RD,
      ST_P1_DAT,
      ST_P1_DIV,
      ST_DIA_PREP,
      ST_DIA_RD,
      ST_DIA_DAT,
      ST_SYS_PREP,
      ST_SYS_RD,
      ST_SYS_DAT,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_DEV_RD,
      ST_DEV_MUL,
      ST_DEV_CMP,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

FILE: src/obpe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module obpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: src/obpe_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obpe_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module obpe_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire obpe_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output obpe_pkg::cmd_type     head
);

   obpe_pkg::cmd_type                      slot_ff [obpe_pkg::FIFO_DEPTH];
   logic [obpe_pkg::FIFO_PTR_W-1:0]        wptr_ff, wptr_in;
   logic [obpe_pkg::FIFO_PTR_W-1:0]        rptr_ff, rptr_in;
   logic [obpe_pkg::FIFO_PTR_W:0]          fill_ff, fill_in;
   logic                                   do_push, do_pop;

   always_comb begin
      full    = (fill_ff == (obpe_pkg::FIFO_PTR_W+1)'(obpe_pkg::FIFO_DEPTH));
      empty   = (fill_ff == '0);
      head    = slot_ff[rptr_ff];
      do_push = push & ~full;
      do_pop  = pop & ~empty;
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff + {{obpe_pkg::FIFO_PTR_W{1'b0}}, do_push}
                        - {{obpe_pkg::FIFO_PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: src/obpe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obpe_front
// Accepts transactions, stores pulse records and queues clear/finish commands.
// ----------------------------------------------------------------------------
module obpe_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire obpe_pkg::req_type              req_data,
   output logic                                req_stall,
   input  wire logic                           fifo_full,
   input  wire logic                           back_done,
   output logic                                push,
   output obpe_pkg::cmd_type                   push_cmd,
   output logic                                ram_we,
   output logic [obpe_pkg::ADDR_W-1:0]         ram_waddr,
   output obpe_pkg::rec_type                   ram_wdata
);

   logic [obpe_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       pend_ff, pend_in;
   logic                       accept, is_load, finish;
   logic [obpe_pkg::CNT_W-1:0] cnt_next;

   always_comb begin
      req_stall = fifo_full | pend_ff;
      accept    = req_valid & ~req_stall;
      is_load   = accept & (req_data.operation == obpe_pkg::OP_LOAD);
      ram_we    = is_load & (cnt_ff < obpe_pkg::CNT_W'(obpe_pkg::MAX_PULSES));
      ram_waddr = cnt_ff[obpe_pkg::ADDR_W-1:0];
      ram_wdata = '{pressure:  req_data.cuff_pressure,
                    amplitude: req_data.amplitude,
                    index:     req_data.sample_index};
      cnt_next  = ram_we ? cnt_ff + 1'b1 : cnt_ff;
      finish    = is_load & req_data.last_pulse;
      push      = finish | (accept & (req_data.operation == obpe_pkg::OP_CLEAR));
      push_cmd.kind  = finish ? obpe_pkg::CMD_FINISH : obpe_pkg::CMD_CLEAR;
      push_cmd.count = cnt_next;
      cnt_in    = finish ? '0 : cnt_next;
      pend_in   = finish | (pend_ff & ~back_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/obpe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obpe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module obpe_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [obpe_pkg::DIV_W-1:0] dividend,
   input  wire logic [15:0]                divisor,
   output logic                            done,
   output logic [obpe_pkg::DIV_W-1:0]      quotient
);

   localparam int CW = $clog2(obpe_pkg::DIV_W);

   logic [obpe_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [15:0]                rem_ff, rem_in;
   logic [15:0]                div_ff, div_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [16:0]                rem_sh, rem_sub;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[obpe_pkg::DIV_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      ge      = (rem_sh >= {1'b0, div_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(obpe_pkg::DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[obpe_pkg::DIV_W-2:0], ge};
         rem_in = ge ? rem_sub[15:0] : rem_sh[15:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: src/obpe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obpe_back
// Executes queued commands: walks the pulse store and builds the run result.
// ----------------------------------------------------------------------------
module obpe_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire obpe_pkg::cfg_type         cfg,
   input  wire logic                      fifo_empty,
   input  wire obpe_pkg::cmd_type         head,
   output logic                           pop,
   output logic [obpe_pkg::ADDR_W-1:0]    ram_raddr,
   input  wire obpe_pkg::rec_type         ram_rdata,
   output logic                           back_done,
   output logic                           rsp_valid,
   output obpe_pkg::rsp_type              rsp_data,
   input  wire logic                      rsp_stall
);

   localparam int AW = obpe_pkg::ADDR_W;
   localparam int NW = obpe_pkg::CNT_W;
   localparam int SW = obpe_pkg::SUM_W;

   obpe_pkg::state_type state_ff, state_in;

   logic [NW-1:0]  n_ff, n_in, i_ff, i_in;
   logic [15:0]    peak_ff, peak_in, map_ff, map_in;
   logic [AW-1:0]  peak_at_ff, peak_at_in;
   logic [15:0]    prev_ff, prev_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [31:0]    prod_ff, prod_in;
   logic [32:0]    best_ff, best_in;
   logic           found_ff, found_in;
   logic [15:0]    sbp_ff, sbp_in, dbp_ff, dbp_in, avg_ff, avg_in;
   logic [SW+15:0] thr_ff, thr_in;
   logic [SW-1:0]  scaled_ff, scaled_in;
   logic [7:0]     beats_ff, beats_in, runs_ff, runs_in;
   logic           run_ff, run_in;
   logic           rv_ff, rv_in;
   obpe_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0]  m;
   logic [NW-1:0]  i_inc;
   logic [15:0]    d, rate, rate_rd;
   logic [32:0]    a_ext, p_ext, err;
   logic [SW-1:0]  dev;
   logic           div_start, div_done;
   logic [obpe_pkg::DIV_W-1:0] div_dvd, div_q;
   logic [15:0]    div_dvs;
   logic           rate_we;
   logic [AW-1:0]  rate_raddr;

   obpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   obpe_ram #(.WIDTH(16), .DEPTH(obpe_pkg::MAX_PULSES)) u_rate_ram (
      .clock (clock),
      .we    (rate_we),
      .waddr (i_ff[AW-1:0]),
      .wdata (rate),
      .raddr (rate_raddr),
      .rdata (rate_rd)
   );

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      peak_in    = peak_ff;
      peak_at_in = peak_at_ff;
      map_in     = map_ff;
      prev_in    = prev_ff;
      sum_in     = sum_ff;
      prod_in    = prod_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      sbp_in     = sbp_ff;
      dbp_in     = dbp_ff;
      avg_in     = avg_ff;
      thr_in     = thr_ff;
      scaled_in  = scaled_ff;
      beats_in   = beats_ff;
      runs_in    = runs_ff;
      run_in     = run_ff;
      rv_in      = rv_ff & rsp_stall;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      back_done  = 1'b0;
      div_start  = 1'b0;
      div_dvd    = obpe_pkg::DIV_W'(obpe_pkg::RATE_SCALE) * obpe_pkg::DIV_W'(cfg.srate);
      div_dvs    = '0;
      rate_we    = 1'b0;
      ram_raddr  = i_ff[AW-1:0];
      rate_raddr = i_ff[AW-1:0];

      m     = AW'(n_ff - 1'b1);
      i_inc = i_ff + 1'b1;
      d     = ram_rdata.index - prev_ff;
      rate  = (|div_q[obpe_pkg::DIV_W-1:16]) ? 16'hFFFF : div_q[15:0];
      a_ext = {1'b0, ram_rdata.amplitude, 16'h0000};
      p_ext = {1'b0, prod_ff};
      err   = (a_ext >= p_ext) ? a_ext - p_ext : p_ext - a_ext;
      dev   = (scaled_ff >= sum_ff) ? scaled_ff - sum_ff : sum_ff - scaled_ff;

      unique case (state_ff)
         obpe_pkg::ST_IDLE: begin
            if (!fifo_empty) begin
               pop = 1'b1;
               if (head.kind == obpe_pkg::CMD_CLEAR) begin
                  runs_in = '0;
               end else begin
                  n_in       = head.count;
                  i_in       = '0;
                  peak_in    = '0;
                  peak_at_in = '0;
                  map_in     = '0;
                  sum_in     = '0;
                  sbp_in     = '0;
                  dbp_in     = '0;
                  avg_in     = '0;
                  beats_in   = '0;
                  run_in     = 1'b0;
                  state_in   = (head.count == '0) ? obpe_pkg::ST_OUT : obpe_pkg::ST_P1_RD;
               end
            end
         end
         obpe_pkg::ST_P1_RD: begin
            state_in = obpe_pkg::ST_P1_DAT;
         end
         obpe_pkg::ST_P1_DAT, obpe_pkg::ST_P1_DIV: begin
            if (state_ff == obpe_pkg::ST_P1_DAT) begin
               if (ram_rdata.amplitude > peak_ff) begin
                  peak_in    = ram_rdata.amplitude;
                  peak_at_in = i_ff[AW-1:0];
                  map_in     = ram_rdata.pressure;
               end
               prev_in = ram_rdata.index;
            end
            if (state_ff == obpe_pkg::ST_P1_DAT && i_ff != '0 && d != '0) begin
               div_start = 1'b1;
               div_dvs   = d;
               state_in  = obpe_pkg::ST_P1_DIV;
            end else if (state_ff == obpe_pkg::ST_P1_DIV && !div_done) begin
               state_in = obpe_pkg::ST_P1_DIV;
            end else begin
               if (i_ff != '0) begin
                  if (state_ff == obpe_pkg::ST_P1_DAT) begin
                     rate = 16'hFFFF;
                  end
                  rate_we = 1'b1;
                  sum_in  = sum_ff + SW'(rate);
               end
               i_in = i_inc;
               if (i_inc == n_ff) begin
                  if ((state_ff == obpe_pkg::ST_P1_DAT && ram_rdata.amplitude > peak_ff)
                      || peak_ff != '0) begin
                     state_in = obpe_pkg::ST_DIA_PREP;
                  end else if (n_ff >= NW'(3)) begin
                     state_in = obpe_pkg::ST_AVG_START;
                  end else begin
                     state_in = obpe_pkg::ST_OUT;
                  end
               end else begin
                  state_in = obpe_pkg::ST_P1_RD;
               end
            end
         end
         obpe_pkg::ST_DIA_PREP: begin
            prod_in  = 32'(cfg.dia_ratio) * 32'(peak_ff);
            found_in = 1'b0;
            i_in     = NW'(peak_at_ff);
            state_in = (peak_at_ff == '0) ? obpe_pkg::ST_SYS_PREP : obpe_pkg::ST_DIA_RD;
         end
         obpe_pkg::ST_DIA_RD: begin
            ram_raddr = AW'(i_ff - 1'b1);
            state_in  = obpe_pkg::ST_DIA_DAT;
         end
         obpe_pkg::ST_DIA_DAT: begin
            if (!found_ff || err < best_ff) begin
               found_in = 1'b1;
               best_in  = err;
               dbp_in   = ram_rdata.pressure;
            end
            i_in     = i_ff - 1'b1;
            state_in = (i_ff == NW'(1)) ? obpe_pkg::ST_SYS_PREP : obpe_pkg::ST_DIA_RD;
         end
         obpe_pkg::ST_SYS_PREP: begin
            prod_in  = 32'(cfg.sys_ratio) * 32'(peak_ff);
            found_in = 1'b0;
            i_in     = NW'(peak_at_ff) + 1'b1;
            if (NW'(peak_at_ff) + 1'b1 >= n_ff) begin
               state_in = (n_ff >= NW'(3)) ? obpe_pkg::ST_AVG_START : obpe_pkg::ST_OUT;
            end else begin
               state_in = obpe_pkg::ST_SYS_RD;
            end
         end
         obpe_pkg::ST_SYS_RD: begin
            state_in = obpe_pkg::ST_SYS_DAT;
         end
         obpe_pkg::ST_SYS_DAT: begin
            if (!found_ff || err < best_ff) begin
               found_in = 1'b1;
               best_in  = err;
               sbp_in   = ram_rdata.pressure;
            end
            i_in = i_inc;
            if (i_inc == n_ff) begin
               state_in = (n_ff >= NW'(3)) ? obpe_pkg::ST_AVG_START : obpe_pkg::ST_OUT;
            end else begin
               state_in = obpe_pkg::ST_SYS_RD;
            end
         end
         obpe_pkg::ST_AVG_START: begin
            div_start = 1'b1;
            div_dvd   = obpe_pkg::DIV_W'(sum_ff);
            div_dvs   = 16'(m);
            thr_in    = (SW+16)'(cfg.dev_ratio) * (SW+16)'(sum_ff);
            state_in  = obpe_pkg::ST_AVG_WAIT;
         end
         obpe_pkg::ST_AVG_WAIT: begin
            if (div_done) begin
               avg_in   = div_q[15:0];
               i_in     = NW'(1);
               state_in = obpe_pkg::ST_DEV_RD;
            end
         end
         obpe_pkg::ST_DEV_RD: begin
            state_in = obpe_pkg::ST_DEV_MUL;
         end
         obpe_pkg::ST_DEV_MUL: begin
            scaled_in = SW'(rate_rd) * SW'(m);
            state_in  = obpe_pkg::ST_DEV_CMP;
         end
         obpe_pkg::ST_DEV_CMP: begin
            if ({dev, 16'h0000} > thr_ff && beats_ff != 8'hFF) begin
               beats_in = beats_ff + 1'b1;
            end
            i_in = i_inc;
            if (i_inc == n_ff) begin
               if ({beats_in, 16'h0000} > 24'(cfg.irr_frac) * 24'(m)) begin
                  run_in = 1'b1;
                  if (runs_ff != 8'hFF) begin
                     runs_in = runs_ff + 1'b1;
                  end
               end
               state_in = obpe_pkg::ST_OUT;
            end else begin
               state_in = obpe_pkg::ST_DEV_RD;
            end
         end
         obpe_pkg::ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in     = 1'b1;
               rsp_in    = '{mean_pressure:       map_ff,
                             systolic_pressure:   sbp_ff,
                             diastolic_pressure:  dbp_ff,
                             pulse_rate:          avg_ff,
                             irregular_beats:     beats_ff,
                             irregular_run:       run_ff,
                             irregular_run_count: runs_ff};
               back_done = 1'b1;
               state_in  = obpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = obpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= obpe_pkg::ST_IDLE;
         runs_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         runs_ff  <= runs_in;
         rv_ff    <= rv_in;
      end
      n_ff       <= n_in;
      i_ff       <= i_in;
      peak_ff    <= peak_in;
      peak_at_ff <= peak_at_in;
      map_ff     <= map_in;
      prev_ff    <= prev_in;
      sum_ff     <= sum_in;
      prod_ff    <= prod_in;
      best_ff    <= best_in;
      found_ff   <= found_in;
      sbp_ff     <= sbp_in;
      dbp_ff     <= dbp_in;
      avg_ff     <= avg_in;
      thr_ff     <= thr_in;
      scaled_ff  <= scaled_in;
      beats_ff   <= beats_in;
      run_ff     <= run_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: src/oscillometric_bp_estimator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oscillometric_bp_estimator_top
// Oscillometric blood pressure estimator with register-set amplitude ratios.
//
// An accepted pulse record is written to the store while it has room. The record
// marked last starts the run evaluation, which holds off every further
// transaction until its result is latched in the output register: a walk of
// the store that finds the peak and computes the interval rates with the
// one-bit-per-cycle 27-bit divider, the diastolic and systolic searches, the
// averaging division and the deviation pass. A clear command resets the
// irregular run count in the back part.
// ----------------------------------------------------------------------------
module oscillometric_bp_estimator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire obpe_pkg::req_type                 req_data,
   output logic                                   req_stall,
   output logic                                   rsp_valid,
   output obpe_pkg::rsp_type                      rsp_data,
   input  wire logic                              rsp_stall,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [obpe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   obpe_pkg::cfg_type   cfg_ff, cfg_in;
   obpe_pkg::csr_idx_type idx;
   logic                wr;

   logic                fifo_full, fifo_empty, push, pop, back_done;
   obpe_pkg::cmd_type   push_cmd, head;
   logic                ram_we;
   logic [obpe_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
   obpe_pkg::rec_type   ram_wdata, ram_rdata;
   logic [47:0]         ram_rbits;

   always_comb begin
      idx    = obpe_pkg::csr_idx_type'(paddr[4:2]);
      wr     = psel & penable & pwrite;
      pready = 1'b1;
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (idx)
         obpe_pkg::CSR_SYS_RATIO: begin
            prdata = {16'h0000, cfg_ff.sys_ratio};
            if (wr) cfg_in.sys_ratio = pwdata[15:0];
         end
         obpe_pkg::CSR_DIA_RATIO: begin
            prdata = {16'h0000, cfg_ff.dia_ratio};
            if (wr) cfg_in.dia_ratio = pwdata[15:0];
         end
         obpe_pkg::CSR_DEV_RATIO: begin
            prdata = {16'h0000, cfg_ff.dev_ratio};
            if (wr) cfg_in.dev_ratio = pwdata[15:0];
         end
         obpe_pkg::CSR_IRR_FRAC: begin
            prdata = {16'h0000, cfg_ff.irr_frac};
            if (wr) cfg_in.irr_frac = pwdata[15:0];
         end
         obpe_pkg::CSR_SRATE: begin
            prdata = {19'h00000, cfg_ff.srate};
            if (wr) cfg_in.srate = pwdata[12:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sys_ratio: obpe_pkg::SYS_RATIO_RST,
                     dia_ratio: obpe_pkg::DIA_RATIO_RST,
                     dev_ratio: obpe_pkg::DEV_RATIO_RST,
                     irr_frac:  obpe_pkg::IRR_FRAC_RST,
                     srate:     obpe_pkg::SRATE_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   obpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .fifo_full (fifo_full),
      .back_done (back_done),
      .push      (push),
      .push_cmd  (push_cmd),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   obpe_ram #(.WIDTH(48), .DEPTH(obpe_pkg::MAX_PULSES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );

   assign ram_rdata = obpe_pkg::rec_type'(ram_rbits);

   obpe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (fifo_full),
      .empty    (fifo_empty),
      .head     (head)
   );

   obpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .head       (head),
      .pop        (pop),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .back_done  (back_done),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the oscillometric blood pressure estimator against a predictor of
// its run evaluation. Pulse runs of random length, clears and stray records
// are fed through the request channel under random idling and stalls, with
// the ratio, deviation and sample-rate registers changed between phases.
// ----------------------------------------------------------------------------
module testbench;

   class bp_scoreboard;
      logic [15:0] sys_r, dia_r, dev_r, irr_f;
      logic [12:0] srate;
      logic [15:0] prs[obpe_pkg::MAX_PULSES];
      logic [15:0] amp[obpe_pkg::MAX_PULSES];
      logic [15:0] idx[obpe_pkg::MAX_PULSES];
      int unsigned held;
      int unsigned irr_runs;
      obpe_pkg::rsp_type pending[$];
      int unsigned errors;
      int unsigned results;

      function new();
         sys_r = obpe_pkg::SYS_RATIO_RST;
         dia_r = obpe_pkg::DIA_RATIO_RST;
         dev_r = obpe_pkg::DEV_RATIO_RST;
         irr_f = obpe_pkg::IRR_FRAC_RST;
         srate = obpe_pkg::SRATE_RST;
         held = 0;
         irr_runs = 0;
         errors = 0;
         results = 0;
      endfunction

      function longint unsigned beat_rate(int unsigned k);
         logic [15:0] d;
         longint unsigned r;
         d = idx[k] - idx[k-1];
         if (d == 0) return 65535;
         r = (64'd15360 * srate) / d;
         return (r > 65535) ? 65535 : r;
      endfunction

      function longint unsigned amp_error(logic [15:0] a, logic [15:0] ratio,
                                          logic [15:0] pk);
         longint unsigned x, y;
         x = longint'(a) << 16;
         y = longint'(ratio) * pk;
         return (x > y) ? x - y : y - x;
      endfunction

      function void note_request(obpe_pkg::req_type r);
         int unsigned n, peak, peak_at, beats;
         longint unsigned best, e, sum, m, scaled, dv;
         bit found;
         obpe_pkg::rsp_type o;
         if (r.operation == obpe_pkg::OP_CLEAR) begin
            irr_runs = 0;
            return;
         end
         if (held < obpe_pkg::MAX_PULSES) begin
            prs[held] = r.cuff_pressure;
            amp[held] = r.amplitude;
            idx[held] = r.sample_index;
            held++;
         end
         if (!r.last_pulse) return;
         o = '0;
         n = held;
         peak = 0;
         peak_at = 0;
         best = 0;
         for (int unsigned i = 0; i < n; i++)
            if (amp[i] > peak) begin
               peak = amp[i];
               peak_at = i;
            end
         if (peak != 0) begin
            o.mean_pressure = prs[peak_at];
            found = 0;
            for (int unsigned i = peak_at; i > 0; i--) begin
               e = amp_error(amp[i-1], dia_r, 16'(peak));
               if (!found || e < best) begin
                  found = 1;
                  best = e;
                  o.diastolic_pressure = prs[i-1];
               end
            end
            found = 0;
            for (int unsigned i = peak_at + 1; i < n; i++) begin
               e = amp_error(amp[i], sys_r, 16'(peak));
               if (!found || e < best) begin
                  found = 1;
                  best = e;
                  o.systolic_pressure = prs[i];
               end
            end
         end
         if (n >= 3) begin
            sum = 0;
            m = n - 1;
            beats = 0;
            for (int unsigned i = 1; i < n; i++) sum += beat_rate(i);
            o.pulse_rate = 16'(sum / m);
            for (int unsigned i = 1; i < n; i++) begin
               scaled = beat_rate(i) * m;
               dv = (scaled > sum) ? scaled - sum : sum - scaled;
               if ((dv << 16) > longint'(dev_r) * sum && beats < 255) beats++;
            end
            o.irregular_beats = 8'(beats);
            if ((longint'(beats) << 16) > longint'(irr_f) * m) begin
               o.irregular_run = 1'b1;
               if (irr_runs < 255) irr_runs++;
            end
         end
         o.irregular_run_count = 8'(irr_runs);
         held = 0;
         pending.push_back(o);
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_result(obpe_pkg::rsp_type r);
         obpe_pkg::rsp_type w;
         results++;
         if (pending.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
         end
         w = pending.pop_front();
         if (r.mean_pressure !== w.mean_pressure)
            report("mean_pressure", r.mean_pressure, w.mean_pressure);
         if (r.systolic_pressure !== w.systolic_pressure)
            report("systolic_pressure", r.systolic_pressure, w.systolic_pressure);
         if (r.diastolic_pressure !== w.diastolic_pressure)
            report("diastolic_pressure", r.diastolic_pressure, w.diastolic_pressure);
         if (r.pulse_rate !== w.pulse_rate)
            report("pulse_rate", r.pulse_rate, w.pulse_rate);
         if (r.irregular_beats !== w.irregular_beats)
            report("irregular_beats", r.irregular_beats, w.irregular_beats);
         if (r.irregular_run !== w.irregular_run)
            report("irregular_run", r.irregular_run, w.irregular_run);
         if (r.irregular_run_count !== w.irregular_run_count)
            report("irregular_run_count", r.irregular_run_count, w.irregular_run_count);
      endtask
   endclass

   localparam int WATCHDOG_LIMIT = 200000;

   logic clock;
   logic reset;
   logic req_valid;
   obpe_pkg::req_type req_data;
   logic req_stall;
   logic rsp_valid;
   obpe_pkg::rsp_type rsp_data;
   logic rsp_stall;
   logic psel, penable, pwrite;
   logic [obpe_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   bp_scoreboard board;
   bit calm;
   int unsigned quiet_cycles;
   int unsigned items_sent;

   oscillometric_bp_estimator_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver stall and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_item(obpe_pkg::req_type r);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      items_sent++;
   endtask

   task automatic csr_write(obpe_pkg::csr_idx_type which, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= obpe_pkg::CSR_ADDR_W'(4 * int'(which));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (which)
         obpe_pkg::CSR_SYS_RATIO: board.sys_r = value[15:0];
         obpe_pkg::CSR_DIA_RATIO: board.dia_r = value[15:0];
         obpe_pkg::CSR_DEV_RATIO: board.dev_r = value[15:0];
         obpe_pkg::CSR_IRR_FRAC:  board.irr_f = value[15:0];
         obpe_pkg::CSR_SRATE:     board.srate = value[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      while (board.pending.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
   endtask

   function automatic obpe_pkg::req_type pulse(logic [15:0] p, logic [15:0] a,
                                               logic [15:0] s, logic fin);
      obpe_pkg::req_type r;
      r.operation = obpe_pkg::OP_LOAD;
      r.cuff_pressure = p;
      r.amplitude = a;
      r.sample_index = s;
      r.last_pulse = fin;
      return r;
   endfunction

   function automatic obpe_pkg::req_type clear_item();
      obpe_pkg::req_type r;
      r = obpe_pkg::req_type'($bits(obpe_pkg::req_type)'({$urandom, $urandom}));
      r.operation = obpe_pkg::OP_CLEAR;
      return r;
   endfunction

   // one realistic deflation run: rising then falling envelope, steady or jittered beats
   task automatic send_run(int unsigned n, bit jitter);
      logic [15:0] s, p, a;
      int unsigned top, step;
      s = $urandom;
      p = 16'($urandom_range(16'hFFFF, 16'h4000));
      top = $urandom_range(n - 1);
      step = $urandom_range(150, 40);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) a = $urandom;
         else if (i <= top) a = 16'(1000 + (i + 1) * 60000 / (top + 1) - $urandom_range(300));
         else a = 16'(61000 - (i - top) * 50000 / n + $urandom_range(300));
         send_item(pulse(p, a, s, i == n - 1));
         p = p - 16'($urandom_range(800));
         s = s + 16'(jitter ? $urandom_range(step * 2, step / 2) : step);
         if ($urandom_range(40) == 0) s = s + 16'($urandom);
      end
   endtask

   initial begin
      int unsigned n;
      board = new();
      calm = 0;
      items_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edge values, short runs, equal samples, ties, clear
      send_item(pulse(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_item(pulse(16'h0000, 16'h0000, 16'h0000, 1'b0));
      send_item(pulse(16'h1234, 16'h0000, 16'h0005, 1'b1));
      send_item(pulse(16'h1000, 16'd100, 16'hFFF0, 1'b0));
      send_item(pulse(16'h2000, 16'd500, 16'h0010, 1'b0));
      send_item(pulse(16'h3000, 16'd500, 16'h0010, 1'b0));
      send_item(pulse(16'h4000, 16'd325, 16'h0080, 1'b0));
      send_item(pulse(16'h5000, 16'd325, 16'h00F0, 1'b1));
      send_item(clear_item());
      send_item(pulse(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
      send_item(pulse(16'h5555, 16'hAAAA, 16'h5555, 1'b1));
      drain();

      csr_write(obpe_pkg::CSR_SYS_RATIO, 32'h0000_0000);
      csr_write(obpe_pkg::CSR_DIA_RATIO, 32'h0000_FFFF);
      csr_write(obpe_pkg::CSR_DEV_RATIO, 32'h0000_0000);
      csr_write(obpe_pkg::CSR_IRR_FRAC, 32'h0000_0000);
      csr_write(obpe_pkg::CSR_SRATE, 32'h0000_1000);
      send_run(5, 1);
      send_run(70, 1);
      drain();
      csr_write(obpe_pkg::CSR_SYS_RATIO, 32'h0000_FFFF);
      csr_write(obpe_pkg::CSR_DIA_RATIO, 32'h0000_0000);
      csr_write(obpe_pkg::CSR_DEV_RATIO, 32'h0000_FFFF);
      csr_write(obpe_pkg::CSR_IRR_FRAC, 32'h0000_FFFF);
      csr_write(obpe_pkg::CSR_SRATE, 32'h0000_0000);
      send_run(6, 1);
      send_run(3, 0);
      drain();
      csr_write(obpe_pkg::CSR_SRATE, 32'h0000_0001);
      send_run(4, 1);
      drain();

      // random phases
      for (int phase = 0; phase < 6; phase++) begin
         csr_write(obpe_pkg::CSR_SYS_RATIO, $urandom_range(16'hFFFF));
         csr_write(obpe_pkg::CSR_DIA_RATIO, $urandom_range(16'hFFFF));
         csr_write(obpe_pkg::CSR_DEV_RATIO, $urandom_range(30000));
         csr_write(obpe_pkg::CSR_IRR_FRAC, $urandom_range(30000));
         csr_write(obpe_pkg::CSR_SRATE, phase == 5 ? 32'd100 : $urandom_range(4096, 1));
         calm = (phase == 3);
         for (int k = 0; k < 22; k++) begin
            case ($urandom_range(9))
               0: send_item(clear_item());
               1: send_item(pulse($urandom, $urandom, $urandom, 1'($urandom)));
               2: send_run($urandom_range(40, 20), 1'($urandom));
               default: begin
                  n = $urandom_range(14, 1);
                  send_run(n, 1'($urandom));
               end
            endcase
         end
         calm = 0;
         drain();
      end
      send_run(8, 1);
      drain();

      $display("fed %0d request transactions, checked %0d results", items_sent,
               board.results);
      $display("covered directed edge runs and six register phases");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: oscillometric_bp_estimator_top.f
src/obpe_pkg.sv
src/obpe_ram.sv
src/obpe_fifo.sv
src/obpe_front.sv
src/obpe_div.sv
src/obpe_back.sv
src/oscillometric_bp_estimator_top.sv
tb/testbench.sv
